// ===== rtl/core/key_value_table_defines.svh =====
// ----------------------------------------------------------------------------
// key_value_table_defines: assertion macros for the key/value table checks
// Each macro expects clk and arst_n to exist in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_DEFINES_SVH
`define KEY_VALUE_TABLE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define KVT_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define KVT_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and codes for the key/value table
// Field widths, operation and status codes, controller command/status structs.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int KVT_DEPTH_DEF = 16;

	localparam int OP_W  = 3;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_REPLACE = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic ready;  // input side may take a word
		logic start;  // word accepted this cycle
		logic scan;   // step the read scan over the table
		logic sweep;  // step the clearing pass
		logic act;    // apply the operation and load the result
	} kvt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_valid;  // a request word is offered
		logic req_scan;   // offered op needs a table scan
		logic req_clear;  // offered op is a clear
		logic done;       // scan or sweep finished
		logic out_free;   // result register can take a new word
	} kvt_stat_t;

endpackage

// ===== rtl/core/kvt_if.sv =====
// ----------------------------------------------------------------------------
// kvt_if: request and response channels of the key/value table
// Valid/ready handshake; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface kvt_req_if;
	import kvt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, op, key, value, input ready);
	modport sink   (input valid, op, key, value, output ready);
endinterface

interface kvt_rsp_if;
	import kvt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] found_value;
	logic [CNT_W-1:0]        entry_count;

	modport source (output valid, status, found_value, entry_count, input ready);
	modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

// ===== rtl/core/kvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvt_ctrl: sequencer for the key/value table
// Runs the reset clearing pass, then per word: scan or sweep if the op needs one, apply, respond.
// ----------------------------------------------------------------------------
module kvt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  kvt_pkg::kvt_stat_t stat,
	output kvt_pkg::kvt_cmd_t  cmd
);
	import kvt_pkg::*;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_ACT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (stat.req_valid) begin
					cmd.start = 1'b1;
					if (stat.req_scan) begin
						state_d = S_SCAN;
					end else if (stat.req_clear) begin
						state_d = S_SWEEP;
					end else begin
						state_d = S_ACT;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.done) begin
					state_d = S_ACT;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.done) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				// wait for room in the result register
				if (stat.out_free) begin
					cmd.act = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/kvt_datapath.sv =====
// ----------------------------------------------------------------------------
// kvt_datapath: entry memory, scan compare, entry count and result register
// One entry read per cycle; the compare runs on the registered read data.
// ----------------------------------------------------------------------------
module kvt_datapath #(
	parameter int TABLE_DEPTH = kvt_pkg::KVT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	kvt_req_if.sink            req,
	kvt_rsp_if.source          rsp,
	input  kvt_pkg::kvt_cmd_t  cmd,
	output kvt_pkg::kvt_stat_t stat
);
	import kvt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// entry memory
	entry_t mem_q [TABLE_DEPTH];

	// scan / sweep
	logic [CW-1:0] iss_q;
	logic          rd_vld_s1;
	logic [AW-1:0] idx_s1;
	entry_t        rd_data_s1;

	// captured request word
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	// scan results
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;

	logic [CW-1:0] count_q;

	// result register
	logic             out_valid_q;
	logic [ST_W-1:0]  res_status_q;
	logic [VAL_W-1:0] res_value_q;
	logic [CNT_W-1:0] res_count_q;

	logic scan_live;
	logic sweep_live;
	logic is_hit;
	logic is_free;

	logic             act_we;
	logic [AW-1:0]    act_wa;
	entry_t           act_wd;
	logic [ST_W-1:0]  nxt_status;
	logic [VAL_W-1:0] nxt_value;
	logic [CW-1:0]    nxt_count;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	entry_t        mem_wd;

	assign scan_live  = cmd.scan && (iss_q != DEPTH_C);
	assign sweep_live = cmd.sweep && (iss_q != DEPTH_C);

	// compare stage on registered read data
	assign is_hit  = rd_vld_s1 && rd_data_s1.vld && (rd_data_s1.key == key_q);
	assign is_free = rd_vld_s1 && !rd_data_s1.vld;

	// status back to the controller
	assign stat.req_valid = req.valid;
	assign stat.req_scan  = req.op inside {OP_INSERT, OP_REPLACE, OP_LOOKUP, OP_REMOVE};
	assign stat.req_clear = (req.op == OP_CLEAR);
	assign stat.done      = (iss_q == DEPTH_C) && !rd_vld_s1;
	assign stat.out_free  = !out_valid_q || rsp.ready;

	// operation apply
	always_comb begin
		act_we     = 1'b0;
		act_wa     = hit_idx_q;
		act_wd     = '{vld: 1'b1, key: key_q, value: value_q};
		nxt_status = ST_OK;
		nxt_value  = '0;
		nxt_count  = count_q;
		case (op_q)
			OP_INSERT: begin
				if (hit_q) begin
					nxt_status = ST_PRESENT;
				end else if (!free_q) begin
					nxt_status = ST_FULL;
				end else begin
					act_we    = 1'b1;
					act_wa    = free_idx_q;
					nxt_count = count_q + CW'(1);
				end
			end
			OP_REPLACE: begin
				if (hit_q) begin
					act_we    = 1'b1;
					nxt_value = value_q;
				end else begin
					nxt_status = ST_MISSING;
				end
			end
			OP_LOOKUP: begin
				if (hit_q) begin
					nxt_value = hit_val_q;
				end else begin
					nxt_status = ST_MISSING;
				end
			end
			OP_REMOVE: begin
				if (hit_q) begin
					act_we     = 1'b1;
					act_wd.vld = 1'b0;
					if (count_q != '0) begin
						nxt_count = count_q - CW'(1);
					end
				end else begin
					nxt_status = ST_MISSING;
				end
			end
			OP_CLEAR: begin
				nxt_count = '0;
			end
			default: begin
			end
		endcase
	end

	// memory write port: clearing pass or operation apply
	assign mem_we = sweep_live || (cmd.act && act_we);
	assign mem_wa = cmd.sweep ? iss_q[AW-1:0] : act_wa;
	assign mem_wd = cmd.sweep ? entry_t'('0) : act_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem_q[iss_q[AW-1:0]];
		idx_s1     <= iss_q[AW-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				iss_q <= '0;
			end else if (scan_live || sweep_live) begin
				iss_q <= iss_q + CW'(1);
			end
			rd_vld_s1 <= scan_live;
			if (cmd.start) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (is_hit) begin
					hit_q <= 1'b1;
				end
				if (is_free) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.act) begin
				count_q <= nxt_count;
			end
			if (cmd.act) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= req.op;
			key_q   <= req.key;
			value_q <= req.value;
		end
		// keys are unique, so only the first hit is kept
		if (is_hit && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= rd_data_s1.value;
		end
		// lowest free slot
		if (is_free && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.act) begin
			res_status_q <= nxt_status;
			res_value_q  <= nxt_value;
			res_count_q  <= CNT_W'(nxt_count);
		end
	end

	assign req.ready       = cmd.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = res_status_q;
	assign rsp.found_value = $signed(res_value_q);
	assign rsp.entry_count = res_count_q;

endmodule

// ===== rtl/core/key_value_table.sv =====
// ----------------------------------------------------------------------------
// key_value_table: bounded table of unique signed keys with signed values
// Insert, replace, lookup and remove scan one entry per cycle through the
// entry memory read port before the op is applied and the result loaded.
// Clear sweeps the memory one entry per cycle; unused ops go straight to apply.
// One word in flight; the next can be taken in the cycle after a result is loaded.
// After reset a clearing pass runs with ready low.
// ----------------------------------------------------------------------------
module key_value_table #(
	parameter int TABLE_DEPTH = kvt_pkg::KVT_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);
	import kvt_pkg::*;

	kvt_cmd_t  cmd;
	kvt_stat_t stat;

	// sequencer
	kvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// table storage and result path
	kvt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

// ===== rtl/core/kvt_checker.sv =====
// ----------------------------------------------------------------------------
// kvt_checker: port-level checks for the key/value table
// Tracks ops of words in flight and checks each result against its op.
// ----------------------------------------------------------------------------
`include "key_value_table_defines.svh"

module kvt_checker #(
	parameter int TABLE_DEPTH = kvt_pkg::KVT_DEPTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [kvt_pkg::OP_W-1:0]       req_op,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [kvt_pkg::ST_W-1:0]       rsp_status,
	input logic signed [kvt_pkg::VAL_W-1:0] rsp_found_value,
	input logic [kvt_pkg::CNT_W-1:0]      rsp_entry_count
);
	import kvt_pkg::*;

	// ops of words accepted but not yet answered (at most two)
	logic [OP_W-1:0] ops_q [2];
	logic [1:0]      n_q;
	logic            push;
	logic            pop;

	assign push = req_valid && req_ready;
	assign pop  = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			ops_q[0] <= '0;
			ops_q[1] <= '0;
		end else begin
			case ({push, pop})
				2'b10: begin
					ops_q[n_q[0]] <= req_op;
					n_q           <= n_q + 2'd1;
				end
				2'b01: begin
					ops_q[0] <= ops_q[1];
					n_q      <= n_q - 2'd1;
				end
				2'b11: begin
					if (n_q == 2'd1) begin
						ops_q[0] <= req_op;
					end else begin
						ops_q[0] <= ops_q[1];
						ops_q[1] <= req_op;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`KVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_value) && $stable(rsp_entry_count), "result word changed while stalled")
	`KVT_ASSERT_NOW(a_count_bound, rsp_valid, (TABLE_DEPTH > 31) || (rsp_entry_count <= TABLE_DEPTH), "entry count above table depth")
	`KVT_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp_status != ST_OK), rsp_found_value == 0, "failed op returned a value")
	`KVT_ASSERT_NOW(a_clear_result, rsp_valid && (ops_q[0] == OP_CLEAR), (rsp_status == ST_OK) && (rsp_entry_count == 0), "clear left entries")
	`KVT_ASSERT_NOW(a_insert_only, rsp_valid && ((rsp_status == ST_PRESENT) || (rsp_status == ST_FULL)), ops_q[0] == OP_INSERT, "present/full status on a non-insert op")

endmodule

bind key_value_table kvt_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_kvt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_op          (req.op),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_value (rsp.found_value),
	.rsp_entry_count (rsp.entry_count)
);

// ===== tb/sv/key_value_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_table_tb: self-checking bench for the key/value table
// A directed table of operations covers the key and value extremes, every
// defined opcode, a spare opcode, duplicate, missing-key and full-table cases
// and clear. Three random phases follow, with different sender and receiver
// idling, checked against a behavioral model of the table kept in the bench.
// ----------------------------------------------------------------------------
module key_value_table_tb;
	import kvt_pkg::*;

	localparam int DEPTH           = KVT_DEPTH_DEF;
	localparam int CLK_HALF        = 10;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int KEY_POOL_N      = 24;
	localparam int LONG_HOLD       = 300;
	localparam int MAX_PRINTS      = 40;

	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] found_value;
		logic [CNT_W-1:0]        entry_count;
	} kvt_result_t;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
		bit                      typed;
		kvt_result_t             want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	kvt_req_if req_ch ();
	kvt_rsp_if rsp_ch ();

	key_value_table #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// model of the table contents
	logic signed [KEY_W-1:0] slot_key  [DEPTH];
	logic signed [VAL_W-1:0] slot_val  [DEPTH];
	bit                      slot_used [DEPTH] = '{default: 1'b0};
	int                      slot_count = 0;

	kvt_result_t expected_results[$];
	stim_row_t   stim_rows[$];

	logic signed [KEY_W-1:0] key_pool [KEY_POOL_N];

	int fail_count    = 0;
	int result_idx    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;
	bit hold_req      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// apply one operation to the model table and return the word it yields
	function automatic kvt_result_t predict_table_op(input logic [OP_W-1:0] op,
			input logic signed [KEY_W-1:0] key, input logic signed [VAL_W-1:0] value);
		kvt_result_t r;
		int hit;
		int free_idx;
		r.status = ST_OK;
		r.found_value = '0;
		hit = -1;
		free_idx = -1;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit < 0 && slot_used[i] && slot_key[i] == key)
				hit = i;
			if (free_idx < 0 && !slot_used[i])
				free_idx = i;
		end
		case (op)
			OP_INSERT: begin
				if (hit >= 0)
					r.status = ST_PRESENT;
				else if (free_idx < 0)
					r.status = ST_FULL;
				else begin
					slot_key[free_idx] = key;
					slot_val[free_idx] = value;
					slot_used[free_idx] = 1'b1;
					slot_count++;
				end
			end
			OP_REPLACE: begin
				if (hit >= 0) begin
					slot_val[hit] = value;
					r.found_value = value;
				end else
					r.status = ST_MISSING;
			end
			OP_LOOKUP: begin
				if (hit >= 0)
					r.found_value = slot_val[hit];
				else
					r.status = ST_MISSING;
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					slot_used[hit] = 1'b0;
					slot_count--;
				end else
					r.status = ST_MISSING;
			end
			OP_CLEAR: begin
				for (int i = 0; i < DEPTH; i++)
					slot_used[i] = 1'b0;
				slot_count = 0;
			end
			default: ;
		endcase
		r.entry_count = CNT_W'(slot_count);
		return r;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op,
			input logic signed [KEY_W-1:0] key, input logic signed [VAL_W-1:0] value,
			input bit typed, input logic [ST_W-1:0] st,
			input logic signed [VAL_W-1:0] fv, input logic [CNT_W-1:0] cnt);
		stim_row_t row;
		row.op = op;
		row.key = key;
		row.value = value;
		row.typed = typed;
		row.want.status = st;
		row.want.found_value = fv;
		row.want.entry_count = cnt;
		stim_rows.push_back(row);
	endfunction

	// offer one request word, wait for acceptance, record what it must produce
	task automatic send_word(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
			input logic signed [VAL_W-1:0] value, input bit typed, input kvt_result_t want);
		kvt_result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.key <= key;
		req_ch.value <= value;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		predicted = predict_table_op(op, key, value);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// sender goes quiet until every outstanding result has come back
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return OP_INSERT;
		if (r < 50)
			return OP_REPLACE;
		if (r < 70)
			return OP_LOOKUP;
		if (r < 90)
			return OP_REMOVE;
		if (r < 93)
			return OP_CLEAR;
		return OP_SPARE_FIRST + OP_W'($urandom_range(OP_SPARE_LAST - OP_SPARE_FIRST));
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			default: return $urandom;
		endcase
	endfunction

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		kvt_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_results.size() == 0)
				report_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
			else begin
				want = expected_results.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("result %0d status got %0d want %0d",
						result_idx, rsp_ch.status, want.status));
				if (rsp_ch.found_value !== want.found_value)
					report_mismatch($sformatf("result %0d found_value got %0d want %0d",
						result_idx, rsp_ch.found_value, want.found_value));
				if (rsp_ch.entry_count !== want.entry_count)
					report_mismatch($sformatf("result %0d entry_count got %0d want %0d",
						result_idx, rsp_ch.entry_count, want.entry_count));
			end
			result_idx++;
		end
	end

	// stimulus
	initial begin
		kvt_result_t no_want;
		logic signed [KEY_W-1:0] key;

		no_want = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_LOOKUP;
		req_ch.key = '0;
		req_ch.value = '0;

		// directed rows: empty table, fill to full, then the corner cases
		add_row(OP_LOOKUP, 0, 0, 1, ST_MISSING, 0, 0);
		add_row(OP_INSERT, KEY_MAX, VAL_MIN, 1, ST_OK, 0, 1);
		add_row(OP_INSERT, KEY_MIN, VAL_MAX, 1, ST_OK, 0, 2);
		for (int i = 1; i <= DEPTH - 2; i++)
			add_row(OP_INSERT, i * 32'sh01010101, -i, 0, ST_OK, 0, 0);
		add_row(OP_INSERT, KEY_MIN, 0, 1, ST_PRESENT, 0, CNT_W'(DEPTH));
		add_row(OP_INSERT, 32'sh5a5a5a5a, 7, 1, ST_FULL, 0, CNT_W'(DEPTH));
		add_row(OP_REPLACE, KEY_MIN, -1, 1, ST_OK, -1, CNT_W'(DEPTH));
		add_row(OP_LOOKUP, KEY_MAX, 0, 1, ST_OK, VAL_MIN, CNT_W'(DEPTH));
		add_row(OP_REMOVE, KEY_MAX, 0, 1, ST_OK, 0, CNT_W'(DEPTH - 1));
		add_row(OP_REMOVE, KEY_MAX, 0, 1, ST_MISSING, 0, CNT_W'(DEPTH - 1));
		add_row(OP_SPARE_LAST, KEY_MIN, VAL_MAX, 1, ST_OK, 0, CNT_W'(DEPTH - 1));
		add_row(OP_CLEAR, 0, 0, 1, ST_OK, 0, 0);
		add_row(OP_REPLACE, KEY_MIN, 5, 1, ST_MISSING, 0, 0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 20;
		recv_idle_pct = 73;
		foreach (stim_rows[i])
			send_word(stim_rows[i].op, stim_rows[i].key, stim_rows[i].value,
				stim_rows[i].typed, stim_rows[i].want);
		drain_results();

		// random phases: a small key pool keeps hits and a full table common
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 73;
					hold_req = 1'b1;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			key_pool[0] = KEY_MIN;
			key_pool[1] = KEY_MAX;
			key_pool[2] = 0;
			key_pool[3] = -1;
			for (int i = 4; i < KEY_POOL_N; i++)
				key_pool[i] = $urandom;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 85)
					key = key_pool[$urandom_range(KEY_POOL_N - 1)];
				else
					key = $urandom;
				send_word(pick_op(), key, pick_value(), 0, no_want);
			end
			drain_results();
		end

		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
